// ----- src/hia_pkg.sv -----
// Package for the handle-to-ID allocator: sizes, command codes and the
// controller/datapath interface structs. No dependencies.
package hia_pkg;

	localparam int SLOTS    = 8;
	localparam int ID_LIMIT = 14;
	localparam int HANDLE_W = 32;

	localparam int ID_W   = 4;
	localparam int CNT_W  = 5;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int IN_W   = ((2 + HANDLE_W + 8 + 7) / 8) * 8;
	localparam int OUT_W  = 16;

	typedef enum logic [1:0] {
		CMD_ALLOC  = 2'd0,
		CMD_FREE   = 2'd1,
		CMD_LOOKUP = 2'd2,
		CMD_CHECK  = 2'd3
	} cmd_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic match;
		logic srch_inc;
		logic grant;
		logic finish;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		cmd_t cmd;
		logic h_zero;
		logic hit;
		logic has_empty;
		logic id_free;
		logic v_last;
		logic out_busy;
	} dp_sts_t;

endpackage

// ----- src/hia_ctrl.sv -----
// Controller for the handle-to-ID allocator: sequences match, ID search
// and commit. Depends on hia_pkg.
module hia_ctrl
	import hia_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_MATCH  = 4'b0010,
		ST_SEARCH = 4'b0100,
		ST_DONE   = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_MATCH;
				end
			end
			ST_MATCH: begin
				cmd.match = 1'b1;
				if (sts.cmd == CMD_ALLOC && !sts.h_zero && !sts.hit && sts.has_empty) begin
					state_d = ST_SEARCH;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SEARCH: begin
				if (sts.id_free) begin
					cmd.grant = 1'b1;
					state_d   = ST_DONE;
				end else if (sts.v_last) begin
					state_d = ST_DONE;
				end else begin
					cmd.srch_inc = 1'b1;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/hia_dp.sv -----
// Datapath for the handle-to-ID allocator: slot table, match and ID-use
// logic, search counter and output register. Depends on hia_pkg.
module hia_dp
	import hia_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,
	input  dp_cmd_t          cmd,
	output dp_sts_t          sts
);

	logic [SLOTS-1:0]        occ_q;
	logic [HANDLE_W-1:0]     hnd_q [SLOTS];
	logic [ID_W-1:0]         sid_q [SLOTS];
	logic [CNT_W-1:0]        cnt_q;

	cmd_t                    rcmd_q;
	logic [HANDLE_W-1:0]     rh_q;
	logic [7:0]              rqid_q;

	logic                    hit_q;
	logic [SLOT_W-1:0]       hit_idx_q;
	logic [SLOT_W-1:0]       emp_idx_q;
	logic [(1<<ID_W)-1:0]    used_q;
	logic [ID_W-1:0]         v_q;
	logic                    grant_q;

	logic                    ovld_q;
	logic                    ook_q;
	logic [ID_W-1:0]         oid_q;
	logic [3:0]              ocnt_q;

	logic                    hit;
	logic                    has_empty;
	logic [SLOT_W-1:0]       hit_idx;
	logic [SLOT_W-1:0]       emp_idx;
	logic [(1<<ID_W)-1:0]    used;
	logic                    h_zero;

	logic                    f_ok;
	logic [ID_W-1:0]         f_id;
	logic [CNT_W-1:0]        f_cnt;

	assign h_zero = (rh_q == '0);

	always_comb begin
		hit       = 1'b0;
		has_empty = 1'b0;
		hit_idx   = '0;
		emp_idx   = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (occ_q[i] && hnd_q[i] == rh_q) begin
				hit     = 1'b1;
				hit_idx = SLOT_W'(i);
			end
			if (!occ_q[i]) begin
				has_empty = 1'b1;
				emp_idx   = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		used = '0;
		for (int j = 0; j < (1 << ID_W); j++) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (j < ID_LIMIT && occ_q[i] && sid_q[i] == ID_W'(j)) begin
					used[j] = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rcmd_q <= cmd_t'(s_tdata[1:0]);
			rh_q   <= s_tdata[2 +: HANDLE_W];
			rqid_q <= s_tdata[2 + HANDLE_W +: 8];
		end
		if (cmd.match) begin
			hit_q     <= hit;
			hit_idx_q <= hit_idx;
			emp_idx_q <= emp_idx;
			used_q    <= used;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q     <= '0;
			grant_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				v_q     <= '0;
				grant_q <= 1'b0;
			end else begin
				if (cmd.srch_inc) begin
					v_q <= v_q + 1'b1;
				end
				if (cmd.grant) begin
					grant_q <= 1'b1;
				end
			end
		end
	end

	// result of the committed request
	always_comb begin
		f_ok  = 1'b0;
		f_id  = '0;
		f_cnt = cnt_q;
		unique case (rcmd_q)
			CMD_ALLOC: begin
				f_ok = grant_q;
				if (grant_q) begin
					f_id  = v_q;
					f_cnt = cnt_q + 1'b1;
				end
			end
			CMD_FREE: begin
				f_ok = !h_zero && hit_q;
				if (f_ok) begin
					f_cnt = cnt_q - 1'b1;
				end
			end
			CMD_LOOKUP: begin
				f_ok = !h_zero && hit_q;
				if (f_ok) begin
					f_id = sid_q[hit_idx_q];
				end
			end
			CMD_CHECK: begin
				f_ok = (rqid_q < 8'(ID_LIMIT)) && used_q[rqid_q[ID_W-1:0]];
			end
			default: begin
				f_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			cnt_q <= '0;
		end else if (cmd.finish) begin
			cnt_q <= f_cnt;
			if (rcmd_q == CMD_ALLOC && grant_q) begin
				occ_q[emp_idx_q] <= 1'b1;
			end else if (rcmd_q == CMD_FREE && f_ok) begin
				occ_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish && rcmd_q == CMD_ALLOC && grant_q) begin
			hnd_q[emp_idx_q] <= rh_q;
			sid_q[emp_idx_q] <= v_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (cmd.finish) begin
			ovld_q <= 1'b1;
		end else if (m_tready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			ook_q  <= f_ok;
			oid_q  <= f_id;
			ocnt_q <= f_cnt[CNT_W-1] ? 4'hF : f_cnt[3:0];
		end
	end

	assign m_tvalid = ovld_q;
	assign m_tdata  = {7'b0, ocnt_q, oid_q, ook_q};

	assign sts.cmd       = rcmd_q;
	assign sts.h_zero    = h_zero;
	assign sts.hit       = hit;
	assign sts.has_empty = has_empty;
	assign sts.id_free   = !used_q[v_q];
	assign sts.v_last    = (v_q == ID_W'(ID_LIMIT - 1));
	assign sts.out_busy  = ovld_q && !m_tready;

`ifndef SYNTH
	a_cnt_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CNT_W'($countones(occ_q)))
		else $error("occupied count out of step with slot table");

	a_ok_id: assert property (@(posedge clk) disable iff (!arst_n)
		ovld_q |-> (ook_q || oid_q == '0))
		else $error("id nonzero on a failed request");

	a_grant_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.grant |-> (!used_q[v_q] && v_q < ID_W'(ID_LIMIT)))
		else $error("granted an ID already in use");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(ovld_q && !m_tready) |-> !cmd.finish)
		else $error("result overwritten before taken");
`endif

endmodule

// ----- src/handle_to_id_allocator.sv -----
// Top level of the handle-to-ID allocator: joins controller and datapath.
// Depends on hia_pkg, hia_ctrl, hia_dp.
//
//  channel | dir | handshake           | tdata fields (lsb first)
//  s       | in  | s_tvalid / s_tready | cmd[1:0] client_handle[33:2] query_id[41:34]
//  m       | out | m_tvalid / m_tready | ok[0] id_out[4:1] used_count[8:5]
//
// Free, lookup and check requests pass through accept, match and commit.
// An allocate refused at match takes the same steps; one that reaches the
// search scans IDs in turn from 0 between match and commit, 1 to 14 of them.
// arst_n clears the slot table valid bits at once.
// A result waits in the output register; the next request is taken
// meanwhile, and commit stalls only while that register is full and not taken.
module handle_to_id_allocator
	import hia_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // cmd, client_handle, query_id, zero pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // ok, id_out, used_count, zero pad
);

	dp_cmd_t dcmd;
	dp_sts_t dsts;

	hia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (dsts),
		.cmd      (dcmd)
	);

	hia_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (dcmd),
		.sts      (dsts)
	);

endmodule
